>>> rtl/ictf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ictf_pkg;

  localparam int NUM_LANES   = 2;
  localparam int FIELD_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SENSITIVITY = 1'd1;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [15:0] GYRO_SENS_RST    = 16'd131;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
  localparam int ATAN_LEN     = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 22;
  localparam int XY_W         = 36;
  localparam int Z_W          = 26;

  // square root
  localparam int SQ_W       = 32;
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 27;
  localparam int SQ_CNT_W   = $clog2(ROOT_W);

  // gyro divider
  localparam int GPROD_W    = 33;
  localparam int DEN_W      = 36;
  localparam int DREM_W     = DEN_W + 1;
  localparam int N_W        = 48;
  localparam int QB         = 29;
  localparam int DIV_CNT_W  = $clog2(QB + 1);
  localparam int INC_W      = QB + 1;
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // blend
  localparam int S_W   = 31;
  localparam int P1_W  = S_W + 17;
  localparam int P2_W  = Z_W + 18;
  localparam int T_W   = P1_W + 1;
  localparam int R_W   = T_W - 25;
  localparam logic signed [R_W-1:0] LIM_POS = R_W'(23040);
  localparam logic signed [R_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [FIELD_W-1:0] OUT_LIM_POS = 16'sd23040;
  localparam logic signed [FIELD_W-1:0] OUT_LIM_NEG = -16'sd23040;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_PREP,
    ST_SQRT,
    ST_CORDIC,
    ST_BLEND_MUL,
    ST_BLEND_SUM,
    ST_WRITE
  } state_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ictf_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ictf_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [ictf_pkg::FIELD_W-1:0] accel_x;
  logic signed [ictf_pkg::FIELD_W-1:0] accel_y;
  logic signed [ictf_pkg::FIELD_W-1:0] accel_z;
  logic signed [ictf_pkg::FIELD_W-1:0] gyro_x;
  logic signed [ictf_pkg::FIELD_W-1:0] gyro_y;
  logic        [ictf_pkg::FIELD_W-1:0] elapsed_us;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us,
                output ready);
endinterface
`default_nettype wire

>>> rtl/ictf_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ictf_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [ictf_pkg::FIELD_W-1:0] angle_x;
  logic signed [ictf_pkg::FIELD_W-1:0] angle_y;
  logic                                saturated;

  modport source (output valid, angle_x, angle_y, saturated, input ready);
  modport sink (input valid, angle_x, angle_y, saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/imu_complementary_tilt_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// complementary tilt filter, accelerometer plus gyro, two axes
// sample channel: one transaction per sensor sample (three accel axes, two gyro
//   axes, elapsed time in us); ready is high only while the block is idle
// result channel: one transaction per sample, angle_x / angle_y in 1/128 degree
//   clamped to +-180 degrees, saturated flags a clamp on either axis
// config port: cfg_wr_en with cfg_index 0 = blend_weight, 1 = gyro_sensitivity,
//   written only while idle (a user's duty, not enforced); takes effect on the next sample
// sequence from the accepting edge to result valid: setup multiplies and prep,
//   the bit-serial square root, the CORDIC vectoring iterations, the blend
//   multiply and sum, then the write state; a new sample is taken only once
//   the block is back in idle; the gyro divider runs alongside the root and
//   cordic and is done by the blend, so the root + cordic chain sets the rate
// both axes run in two lanes side by side through the same sequence
// a finished result sits in an output register; the next sample is taken while
//   it waits; if the receiver still stalls when the following result is ready,
//   the block holds in its write state
// reset (rst, synchronous) clears both kept angles, restores the register
//   defaults and drops any pending result
module imu_complementary_tilt_filter_top (
  input  logic                              clk,
  input  logic                              rst,
  ictf_sample_if.sink                       sample,
  ictf_result_if.source                     result,
  input  logic                              cfg_wr_en,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ictf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import ictf_pkg::*;

  state_t state, state_next;

  logic [15:0] blend_weight;
  logic [15:0] gyro_sensitivity;

  // kept angles, lane 0 is x, lane 1 is y
  logic signed [FIELD_W-1:0] angle [NUM_LANES];

  // captured operands
  logic signed [FIELD_W-1:0] u_op   [NUM_LANES];
  logic signed [FIELD_W-1:0] v_op   [NUM_LANES];
  logic signed [FIELD_W:0]   num_op [NUM_LANES];
  logic                      num_zero [NUM_LANES];
  logic signed [FIELD_W-1:0] g_op   [NUM_LANES];
  logic [FIELD_W-1:0]        us_op;

  // square root lanes
  logic [SQ_W-1:0]   sq_a [NUM_LANES];
  logic [SQ_W-1:0]   sq_b [NUM_LANES];
  logic [RAD_W-1:0]  rad  [NUM_LANES];
  logic [REM_W-1:0]  rem  [NUM_LANES];
  logic [ROOT_W-1:0] root [NUM_LANES];
  logic [SQ_CNT_W-1:0] sq_cnt;

  // cordic lanes
  logic signed [XY_W-1:0] cx [NUM_LANES];
  logic signed [XY_W-1:0] cy [NUM_LANES];
  logic signed [Z_W-1:0]  cz [NUM_LANES];
  logic [CSTEP_W-1:0]     cstep;

  // gyro divider lanes
  logic signed [GPROD_W-1:0] gprod [NUM_LANES];
  logic [DEN_W-1:0]          den;
  logic                      gneg  [NUM_LANES];
  logic [DREM_W-1:0]         drem  [NUM_LANES];
  logic [QB-1:0]             nlow  [NUM_LANES];
  logic [QB-1:0]             quot  [NUM_LANES];
  logic [DIV_CNT_W-1:0]      div_cnt;

  // blend
  logic signed [P1_W-1:0] p1 [NUM_LANES];
  logic signed [P2_W-1:0] p2 [NUM_LANES];
  logic                   sat_pend;

  // output register
  logic                      res_valid;
  logic signed [FIELD_W-1:0] res_x;
  logic signed [FIELD_W-1:0] res_y;
  logic                      res_sat;

  // combinational step values
  logic [REM_W-1:0]       rem_sh    [NUM_LANES];
  logic [REM_W-1:0]       trial     [NUM_LANES];
  logic                   sq_ge     [NUM_LANES];
  logic [REM_W-1:0]       rem_new   [NUM_LANES];
  logic [ROOT_W-1:0]      root_new  [NUM_LANES];
  logic signed [XY_W-1:0] dx        [NUM_LANES];
  logic signed [XY_W-1:0] dy        [NUM_LANES];
  logic signed [Z_W-1:0]  angz;
  logic [DREM_W-1:0]      drem_sh   [NUM_LANES];
  logic                   div_ge    [NUM_LANES];
  logic [DREM_W-1:0]      drem_new  [NUM_LANES];
  logic signed [GPROD_W-1:0] gmag   [NUM_LANES];
  logic [N_W-1:0]         nval      [NUM_LANES];
  logic signed [INC_W-1:0] inc      [NUM_LANES];
  logic signed [S_W-1:0]  s_sum     [NUM_LANES];
  logic signed [Z_W-1:0]  acc       [NUM_LANES];
  logic signed [T_W-1:0]  t_sum     [NUM_LANES];
  logic signed [R_W-1:0]  rq        [NUM_LANES];
  logic signed [FIELD_W-1:0] clamped [NUM_LANES];
  logic                   clamp_hit [NUM_LANES];
  logic signed [16:0]     alpha_s;
  logic signed [17:0]     beta_s;
  logic [15:0]            sens_eff;
  logic                   sample_acc;
  logic                   res_load;

  assign sample.ready   = (state == ST_IDLE);
  assign sample_acc     = sample.valid && sample.ready;
  assign result.valid     = res_valid;
  assign result.angle_x   = res_x;
  assign result.angle_y   = res_y;
  assign result.saturated = res_sat;

  assign alpha_s  = signed'({1'b0, blend_weight});
  assign beta_s   = 18'sd65536 - 18'(alpha_s);
  assign sens_eff = (gyro_sensitivity == 16'd0) ? 16'd1 : gyro_sensitivity;
  assign angz     = {{(Z_W-ATAN_W){1'b0}}, atan_q16(ATAN_IDX_W'(cstep))};
  assign res_load = (state == ST_WRITE) && (!res_valid || result.ready);

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      // one root bit per cycle
      rem_sh[l]   = {rem[l][REM_W-3:0], rad[l][RAD_W-1 -: 2]};
      trial[l]    = {1'b0, root[l], 2'b01};
      sq_ge[l]    = (rem_sh[l] >= trial[l]);
      rem_new[l]  = sq_ge[l] ? (rem_sh[l] - trial[l]) : rem_sh[l];
      root_new[l] = {root[l][ROOT_W-2:0], sq_ge[l]};
      // cordic shifts
      dx[l] = cy[l] >>> cstep;
      dy[l] = cx[l] >>> cstep;
      // one quotient bit per cycle
      drem_sh[l]  = {drem[l][DEN_W-1:0], nlow[l][QB-1]};
      div_ge[l]   = (drem_sh[l] >= {1'b0, den});
      drem_new[l] = div_ge[l] ? (drem_sh[l] - {1'b0, den}) : drem_sh[l];
      // dividend with half the divisor added for rounding
      gmag[l] = gprod[l][GPROD_W-1] ? -gprod[l] : gprod[l];
      nval[l] = {gmag[l][31:0], 16'd0} + N_W'(den >> 1);
      // blend terms
      inc[l]   = gneg[l] ? -signed'({1'b0, quot[l]}) : signed'({1'b0, quot[l]});
      s_sum[l] = {{(S_W-FIELD_W-9){angle[l][FIELD_W-1]}}, angle[l], 9'd0}
               + {{(S_W-INC_W){inc[l][INC_W-1]}}, inc[l]};
      // flat vector: no tilt
      acc[l]   = (root[l] == '0 && num_zero[l]) ? '0 : cz[l];
      t_sum[l] = {{(T_W-P1_W){p1[l][P1_W-1]}}, p1[l]}
               + {{(T_W-P2_W){p2[l][P2_W-1]}}, p2[l]}
               + T_W'(1 << 24);
      rq[l]    = t_sum[l][T_W-1:25];
      clamp_hit[l] = 1'b0;
      clamped[l]   = rq[l][FIELD_W-1:0];
      if (rq[l] > LIM_POS) begin
        clamped[l]   = OUT_LIM_POS;
        clamp_hit[l] = 1'b1;
      end else if (rq[l] < LIM_NEG) begin
        clamped[l]   = OUT_LIM_NEG;
        clamp_hit[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (sample_acc) state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_PREP;
      ST_PREP:      state_next = ST_SQRT;
      ST_SQRT:      if (sq_cnt == SQ_CNT_W'(ROOT_W - 1)) state_next = ST_CORDIC;
      ST_CORDIC:    if (cstep == CSTEP_W'(CORDIC_STEPS - 1)) state_next = ST_BLEND_MUL;
      ST_BLEND_MUL: state_next = ST_BLEND_SUM;
      ST_BLEND_SUM: state_next = ST_WRITE;
      ST_WRITE:     if (res_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight     <= BLEND_WEIGHT_RST;
      gyro_sensitivity <= GYRO_SENS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT:     blend_weight     <= cfg_wr_data;
        REG_GYRO_SENSITIVITY: gyro_sensitivity <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // kept angles and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      angle[0] <= '0;
      angle[1] <= '0;
      sq_cnt   <= '0;
      cstep    <= '0;
      div_cnt  <= '0;
      sat_pend <= 1'b0;
    end else begin
      if (state == ST_PREP) begin
        sq_cnt  <= '0;
        cstep   <= '0;
        div_cnt <= DIV_CNT_W'(QB);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (state == ST_SQRT) sq_cnt <= sq_cnt + 1'b1;
      if (state == ST_CORDIC) cstep <= cstep + 1'b1;
      if (state == ST_BLEND_SUM) begin
        angle[0] <= clamped[0];
        angle[1] <= clamped[1];
        sat_pend <= clamp_hit[0] || clamp_hit[1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_x   <= angle[0];
      res_y   <= angle[1];
      res_sat <= sat_pend;
    end
  end

  // datapath lanes
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      u_op[0]     <= sample.accel_x;
      v_op[0]     <= sample.accel_z;
      num_op[0]   <= 17'(sample.accel_y);
      num_zero[0] <= (sample.accel_y == '0);
      g_op[0]     <= sample.gyro_x;
      u_op[1]     <= sample.accel_y;
      v_op[1]     <= sample.accel_z;
      num_op[1]   <= -17'(sample.accel_x);
      num_zero[1] <= (sample.accel_x == '0);
      g_op[1]     <= sample.gyro_y;
      us_op       <= sample.elapsed_us;
    end
    if (state == ST_MUL1) begin
      den <= sens_eff * US_PER_S;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (state == ST_MUL1) begin
        sq_a[l]  <= u_op[l] * u_op[l];
        gprod[l] <= g_op[l] * signed'({1'b0, us_op});
      end
      if (state == ST_MUL2) begin
        sq_b[l] <= v_op[l] * v_op[l];
      end
      if (state == ST_PREP) begin
        rad[l]  <= {sq_a[l] + sq_b[l], 16'd0};
        rem[l]  <= '0;
        root[l] <= '0;
        gneg[l] <= gprod[l][GPROD_W-1];
        drem[l] <= DREM_W'(nval[l][N_W-1:QB]);
        nlow[l] <= nval[l][QB-1:0];
        quot[l] <= '0;
      end
      if (state == ST_SQRT) begin
        rad[l]  <= {rad[l][RAD_W-3:0], 2'b00};
        rem[l]  <= rem_new[l];
        root[l] <= root_new[l];
        if (sq_cnt == SQ_CNT_W'(ROOT_W - 1)) begin
          cx[l] <= {{(XY_W-ROOT_W-8){1'b0}}, root_new[l], 8'd0};
          cy[l] <= {{(XY_W-FIELD_W-17){num_op[l][FIELD_W]}}, num_op[l], 16'd0};
          cz[l] <= '0;
        end
      end
      if (state == ST_CORDIC) begin
        if (!cy[l][XY_W-1]) begin
          cx[l] <= cx[l] + dx[l];
          cy[l] <= cy[l] - dy[l];
          cz[l] <= cz[l] + angz;
        end else begin
          cx[l] <= cx[l] - dx[l];
          cy[l] <= cy[l] + dy[l];
          cz[l] <= cz[l] - angz;
        end
      end
      if (state != ST_PREP && div_cnt != '0) begin
        drem[l] <= drem_new[l];
        nlow[l] <= {nlow[l][QB-2:0], 1'b0};
        quot[l] <= {quot[l][QB-2:0], div_ge[l]};
      end
      if (state == ST_BLEND_MUL) begin
        p1[l] <= alpha_s * s_sum[l];
        p2[l] <= beta_s * acc[l];
      end
    end
  end

`ifndef ASSERT_OFF
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_BLEND_MUL |-> div_cnt == '0)
    else $error("gyro divider still busy at blend");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == ST_MUL1)
    else $error("accepted sample did not start");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.angle_x <= OUT_LIM_POS && result.angle_x >= OUT_LIM_NEG &&
                     result.angle_y <= OUT_LIM_POS && result.angle_y >= OUT_LIM_NEG)
    else $error("result angle out of range");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      result.angle_x == OUT_LIM_POS || result.angle_x == OUT_LIM_NEG ||
      result.angle_y == OUT_LIM_POS || result.angle_y == OUT_LIM_NEG)
    else $error("saturated flag without clamped angle");
`endif
endmodule
`default_nettype wire

>>> dv/ictf_tb_if.sv
`timescale 1ns / 1ps
// the channel interfaces come with the block (rtl/ictf_sample_if.sv and
// rtl/ictf_result_if.sv); this file only carries the shared sample record
package ictf_tb_pkg;
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic        [15:0] us;
  } imu_sample_t;
endpackage

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ictf_pkg::*;
  import ictf_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  ictf_sample_if sample ();
  ictf_result_if result ();

  imu_complementary_tilt_filter_top dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // angle predictor: mirrors the block's arithmetic on 64-bit integers
  class tilt_scoreboard;
    logic [15:0] alpha;
    logic [15:0] sens;
    logic signed [15:0] kept [2];
    logic [32:0] pending [$];
    int errors;
    int checked;
    int sat_seen;

    function new();
      alpha = BLEND_WEIGHT_RST;
      sens = GYRO_SENS_RST;
      kept[0] = 0;
      kept[1] = 0;
      errors = 0;
      checked = 0;
      sat_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_BLEND_WEIGHT) alpha = val;
      else if (idx == REG_GYRO_SENSITIVITY) sens = val;
    endfunction

    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint isqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function longint atan_table(int i);
      longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
      return t[i];
    endfunction

    // tilt of num against the magnitude of (u, v), Q16 degrees
    function longint tilt_q16(longint num, longint u, longint v);
      longint root;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      root = isqrt((u * u + v * v) << 16);
      z = 0;
      if (root == 0 && num == 0) return 0;
      x = root * 256;
      y = num * 65536;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_table(i);
        end else begin
          x -= dx; y += dy; z -= atan_table(i);
        end
      end
      return z;
    endfunction

    function longint rate_step(longint g, longint us);
      longint num;
      longint den;
      longint mag;
      longint q;
      num = g * us * 65536;
      den = (sens == 0 ? 64'd1 : longint'(sens)) * 1000000;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function longint mix(int lane, longint acc, longint inc, ref bit sat);
      longint s;
      longint t;
      longint r;
      s = longint'(kept[lane]) * 512 + inc;
      t = longint'(alpha) * s + (65536 - longint'(alpha)) * acc;
      r = floor_shift(t + (64'd1 << 24), 25);
      if (r > 23040) begin r = 23040; sat = 1; end
      if (r < -23040) begin r = -23040; sat = 1; end
      kept[lane] = 16'(r);
      return r;
    endfunction

    function void note_sample(imu_sample_t smp);
      bit sat;
      longint rx;
      longint ry;
      longint ax;
      longint ay;
      longint az;
      sat = 0;
      ax = smp.ax; ay = smp.ay; az = smp.az;
      rx = mix(0, tilt_q16(ay, ax, az), rate_step(smp.gx, smp.us), sat);
      ry = mix(1, tilt_q16(-ax, ay, az), rate_step(smp.gy, smp.us), sat);
      pending.push_back({rx[15:0], ry[15:0], sat});
    endfunction

    function void check_result(logic [15:0] ax, logic [15:0] ay, logic s);
      logic [32:0] exp_v;
      checked++;
      if (s === 1'b1) sat_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h %h %b", ax, ay, s);
        return;
      end
      exp_v = pending.pop_front();
      if (exp_v !== {ax, ay, s}) begin
        errors++;
        if (errors <= 10)
          $display("result %0d mismatch: exp x=%0d y=%0d sat=%b, got x=%0d y=%0d sat=%b",
                   checked, $signed(exp_v[32:17]), $signed(exp_v[16:1]), exp_v[0],
                   $signed(ax), $signed(ay), s);
      end
    endfunction
  endclass

  tilt_scoreboard board = new();

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;

  // sample results at the rising edge
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      board.check_result(result.angle_x, result.angle_y, result.saturated);
  end

  // receiver backpressure, changes on the falling edge
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // the block stays busy for many cycles after each accept, so the extra
  // falling edge before a new transaction costs no throughput
  task automatic send_sample(imu_sample_t smp);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    sample.valid <= 1;
    sample.accel_x <= smp.ax; sample.accel_y <= smp.ay; sample.accel_z <= smp.az;
    sample.gyro_x <= smp.gx; sample.gyro_y <= smp.gy; sample.elapsed_us <= smp.us;
    do @(posedge clk); while (!sample.ready);
    board.note_sample(smp);
    samples_sent++;
    @(negedge clk);
    sample.valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t rand_sample(bit realistic);
    imu_sample_t s;
    s = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
    // mostly plausible sensor data: 1 g near 16384, modest rates, ms timestep
    if (realistic) begin
      s.ax = 16'($urandom_range(32768)) - 16'd16384;
      s.ay = 16'($urandom_range(32768)) - 16'd16384;
      s.az = 16'($urandom_range(32768)) - 16'd16384;
      s.gx = 16'($urandom_range(8000)) - 16'd4000;
      s.gy = 16'($urandom_range(8000)) - 16'd4000;
      s.us = 16'($urandom_range(20000));
    end
    return s;
  endfunction

  initial begin
    imu_sample_t s;
    sample.valid = 0;
    sample.accel_x = 0; sample.accel_y = 0; sample.accel_z = 0;
    sample.gyro_x = 0; sample.gyro_y = 0; sample.elapsed_us = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: zero vector, root-zero cases, field extremes, clamping
    send_sample('{0, 0, 0, 0, 0, 0});
    send_sample('{0, 16384, 0, 0, 0, 1000});
    send_sample('{-16384, 0, 0, 0, 0, 1000});
    send_sample('{0, 0, 16384, 0, 0, 0});
    send_sample('{-32768, -32768, -32768, -32768, -32768, 16'hffff});
    send_sample('{32767, 32767, 32767, 32767, 32767, 16'hffff});
    send_sample('{0, -32768, 0, 32767, -32768, 16'hffff});
    for (int i = 0; i < 4; i++) send_sample('{0, 32767, 0, 32767, 32767, 16'hffff});
    for (int i = 0; i < 4; i++) send_sample('{0, -32768, 0, -32768, -32768, 16'hffff});
    drain();
    // zero sensitivity acts as one, alpha at its extremes
    write_reg(REG_GYRO_SENSITIVITY, 16'd0);
    write_reg(REG_BLEND_WEIGHT, 16'hffff);
    send_sample('{100, -200, 16000, 32767, -32768, 16'hffff});
    send_sample('{-100, 200, 16000, -5, 5, 50});
    drain();
    write_reg(REG_BLEND_WEIGHT, 16'd0);
    write_reg(REG_GYRO_SENSITIVITY, 16'hffff);
    send_sample('{3000, -3000, 16000, 32767, -32768, 16'hffff});
    send_sample('{-32768, 32767, -1, 1, -1, 1});
    drain();

    // random phases with varied idling and register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 55; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 55; end
        default: begin src_idle_pct = 35; snk_stall_pct = 35; end
      endcase
      case (ph)
        0: begin write_reg(REG_BLEND_WEIGHT, BLEND_WEIGHT_RST);
                 write_reg(REG_GYRO_SENSITIVITY, GYRO_SENS_RST); end
        1: begin write_reg(REG_BLEND_WEIGHT, 16'hffff);
                 write_reg(REG_GYRO_SENSITIVITY, 16'd1); end
        2: begin write_reg(REG_BLEND_WEIGHT, 16'd0);
                 write_reg(REG_GYRO_SENSITIVITY, 16'hffff); end
        default: begin write_reg(REG_BLEND_WEIGHT, 16'($urandom));
                       write_reg(REG_GYRO_SENSITIVITY, 16'($urandom_range(1, 65535))); end
      endcase
      for (int i = 0; i < 141; i++) begin
        s = rand_sample($urandom_range(99) < 75);
        send_sample(s);
        // sender waits out every outstanding result once per phase
        if (i == 70) while (board.pending.size() != 0) @(negedge clk);
      end
      drain();
    end

    snk_stall_pct = 0;
    drain();
    $display("covered %0d samples, %0d results checked, %0d with a clamp",
             samples_sent, board.checked, board.sat_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", board.errors + board.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
